// File: rtl/core/slcfc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame checker.
`default_nettype none

package slcfc_pkg;

    localparam logic [7:0]  SYNC_BYTE         = 8'h55;
    localparam logic [7:0]  END_BYTE          = 8'haa;
    localparam logic [15:0] CRC_INIT          = 16'hffff;
    localparam logic [7:0]  WANTED_TYPE_RESET = 8'h02;
    localparam int          TDATA_OUT_W       = 40;

    // Frame parser phases, one-hot
    typedef enum logic [8:0] {
        ST_HUNT    = 9'b000000001,
        ST_TYPE    = 9'b000000010,
        ST_SEQ     = 9'b000000100,
        ST_LEN_LO  = 9'b000001000,
        ST_LEN_HI  = 9'b000010000,
        ST_PAYLOAD = 9'b000100000,
        ST_CRC_LO  = 9'b001000000,
        ST_CRC_HI  = 9'b010000000,
        ST_END     = 9'b100000000
    } phase_t;

    // Per-frame report
    typedef struct packed {
        logic [7:0]  frame_type;
        logic [7:0]  sequence_byte;
        logic [15:0] frame_len;
        logic        end_ok;
        logic        crc_ok;
        logic        accepted;
    } result_t;

    // CRC-16/CCITT-FALSE, one byte, poly 0x1021, MSB first
    function automatic logic [15:0] crc16_feed(input logic [15:0] acc, input logic [7:0] b);
        logic [7:0] x;
        x = acc[15:8] ^ b;
        x = x ^ {4'h0, x[7:4]};
        return {acc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/slcfc_parser.sv
// Byte-wise frame parser: sync hunt, header capture, CRC update, end check.
`default_nettype none

module slcfc_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              byte_valid,
    input  wire logic [7:0]        byte_data,
    input  wire logic [7:0]        wanted_type,
    output logic                   done,
    output slcfc_pkg::result_t     result
);

    slcfc_pkg::phase_t state_reg, state_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  seq_reg, seq_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic [15:0] crc_fed;
    logic [16:0] count_inc;
    logic [15:0] length_full;
    logic        end_ok;
    logic        crc_ok;

    assign crc_fed     = slcfc_pkg::crc16_feed(crc_reg, byte_data);
    assign count_inc   = {1'b0, count_reg} + 17'd1;
    assign length_full = {byte_data, length_reg[7:0]};
    assign end_ok      = (byte_data == slcfc_pkg::END_BYTE);
    assign crc_ok      = (rx_crc_reg == crc_reg);

    // Next-state logic, applied on each byte transfer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        length_next = length_reg;
        type_next   = type_reg;
        seq_next    = seq_reg;
        rx_crc_next = rx_crc_reg;
        done        = 1'b0;
        if (byte_valid) begin
            case (state_reg)
                slcfc_pkg::ST_HUNT: begin
                    if (byte_data == slcfc_pkg::SYNC_BYTE) begin
                        crc_next   = slcfc_pkg::CRC_INIT;
                        count_next = 16'd0;
                        state_next = slcfc_pkg::ST_TYPE;
                    end
                end
                slcfc_pkg::ST_TYPE: begin
                    type_next  = byte_data;
                    crc_next   = crc_fed;
                    state_next = slcfc_pkg::ST_SEQ;
                end
                slcfc_pkg::ST_SEQ: begin
                    seq_next   = byte_data;
                    crc_next   = crc_fed;
                    state_next = slcfc_pkg::ST_LEN_LO;
                end
                slcfc_pkg::ST_LEN_LO: begin
                    length_next = {8'h00, byte_data};
                    crc_next    = crc_fed;
                    state_next  = slcfc_pkg::ST_LEN_HI;
                end
                slcfc_pkg::ST_LEN_HI: begin
                    length_next = length_full;
                    crc_next    = crc_fed;
                    count_next  = 16'd0;
                    state_next  = (length_full == 16'd0) ? slcfc_pkg::ST_CRC_LO
                                                         : slcfc_pkg::ST_PAYLOAD;
                end
                slcfc_pkg::ST_PAYLOAD: begin
                    crc_next = crc_fed;
                    if (count_inc >= {1'b0, length_reg}) begin
                        count_next = 16'd0;
                        state_next = slcfc_pkg::ST_CRC_LO;
                    end else begin
                        count_next = count_inc[15:0];
                    end
                end
                slcfc_pkg::ST_CRC_LO: begin
                    rx_crc_next = {8'h00, byte_data};
                    state_next  = slcfc_pkg::ST_CRC_HI;
                end
                slcfc_pkg::ST_CRC_HI: begin
                    rx_crc_next = {byte_data, rx_crc_reg[7:0]};
                    state_next  = slcfc_pkg::ST_END;
                end
                slcfc_pkg::ST_END: begin
                    done       = 1'b1;
                    count_next = 16'd0;
                    state_next = slcfc_pkg::ST_HUNT;
                end
                default: begin
                    state_next = slcfc_pkg::ST_HUNT;
                end
            endcase
        end
    end

    // Report for the end byte
    always_comb begin
        result.frame_type    = type_reg;
        result.sequence_byte = seq_reg;
        result.frame_len     = length_reg;
        result.end_ok        = end_ok;
        result.crc_ok        = crc_ok;
        result.accepted      = end_ok && crc_ok && (type_reg == wanted_type);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= slcfc_pkg::ST_HUNT;
            count_reg <= 16'd0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Frame fields and CRC accumulator
    always_ff @(posedge aclk) begin
        crc_reg    <= crc_next;
        length_reg <= length_next;
        type_reg   <= type_next;
        seq_reg    <= seq_next;
        rx_crc_reg <= rx_crc_next;
    end

    // A finished frame always returns to sync hunt
    a_done_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> (state_reg == slcfc_pkg::ST_HUNT))
        else $error("parser did not return to hunt after end byte");

    // Payload phase is only entered with a nonzero length
    a_payload_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == slcfc_pkg::ST_PAYLOAD) |-> (length_reg != 16'd0))
        else $error("payload phase with zero length");

    // Payload counter stays below the header length
    a_payload_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == slcfc_pkg::ST_PAYLOAD) |-> (count_reg < length_reg))
        else $error("payload counter overran length");

endmodule

`default_nettype wire

// File: rtl/core/sync_length_crc_frame_checker_unit.sv
// Output: the report is registered and appears on m_axis in the cycle after the end byte transfer.
// Throughput: one byte per cycle; input stalls only while a report waits on m_axis_tready.
// The output register decouples the sides, so a byte is taken while a report is held and taken.
// Reset: synchronous, active-low aresetn; parser hunts for sync, output empty, wanted_type = 2.
// Top level: frame checker with config register and registered result stream.
`default_nettype none

module sync_length_crc_frame_checker_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,   // wanted_type
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] frame_type, [15:8] sequence_byte, [31:16] frame_len,
    // [32] end_ok, [33] crc_ok, [34] accepted, [39:35] zero
    output logic [slcfc_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);

    logic [7:0]          wanted_reg;
    logic                in_xfer;
    logic                done;
    slcfc_pkg::result_t  result;
    logic                out_valid_reg;
    slcfc_pkg::result_t  out_data_reg;

    // Input side: take a byte unless a report sits unclaimed
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_reg <= slcfc_pkg::WANTED_TYPE_RESET;
        end else if (cfg_wr_en) begin
            wanted_reg <= cfg_wr_data;
        end
    end

    slcfc_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_valid  (in_xfer),
        .byte_data   (s_axis_tdata),
        .wanted_type (wanted_reg),
        .done        (done),
        .result      (result)
    );

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (done) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (done) begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000,
                            out_data_reg.accepted,
                            out_data_reg.crc_ok,
                            out_data_reg.end_ok,
                            out_data_reg.frame_len,
                            out_data_reg.sequence_byte,
                            out_data_reg.frame_type};

    // A report never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_axis_tready) |-> !done)
        else $error("report overwritten before transfer");

    // Acceptance requires both end and CRC checks
    a_accept_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg.accepted) |-> (out_data_reg.end_ok && out_data_reg.crc_ok))
        else $error("accepted without end and crc ok");

    // Held report stays put while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(out_valid_reg && !m_axis_tready) |-> $stable(out_data_reg))
        else $error("stalled report changed");

endmodule

`default_nettype wire
